@@ sv/sse_pkg.sv @@
`default_nettype none
package sse_pkg;

  // store geometry
  localparam int MAX_ITEMS = 64;
  localparam int AW        = $clog2(MAX_ITEMS);
  localparam int CW        = AW + 1;

  // config port
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam logic REG_DESCENDING = 1'b0;

  typedef struct packed {
    logic signed [31:0] value;
    logic               is_last;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               is_last_res;
    logic               overflowed;
  } out_word_t;

  // microcode step addresses
  localparam int PCW = 4;
  localparam logic [PCW-1:0] ST_LOAD     = 4'd0;
  localparam logic [PCW-1:0] ST_GINIT    = 4'd1;
  localparam logic [PCW-1:0] ST_GTEST    = 4'd2;
  localparam logic [PCW-1:0] ST_JINIT    = 4'd3;
  localparam logic [PCW-1:0] ST_RDJ      = 4'd4;
  localparam logic [PCW-1:0] ST_HOLD     = 4'd5;
  localparam logic [PCW-1:0] ST_CMP      = 4'd6;
  localparam logic [PCW-1:0] ST_MOVE     = 4'd7;
  localparam logic [PCW-1:0] ST_PUT      = 4'd8;
  localparam logic [PCW-1:0] ST_GNEXT    = 4'd9;
  localparam logic [PCW-1:0] ST_EMIT_RD  = 4'd10;
  localparam logic [PCW-1:0] ST_EMIT_OUT = 4'd11;
  localparam logic [PCW-1:0] ST_DONE     = 4'd12;

  // wait conditions: the step holds until its condition is met
  localparam logic [1:0] WT_NONE     = 2'd0;
  localparam logic [1:0] WT_IN_LAST  = 2'd1;
  localparam logic [1:0] WT_OUT_FREE = 2'd2;

  // jump conditions
  localparam logic [2:0] JC_NONE      = 3'd0;
  localparam logic [2:0] JC_ALWAYS    = 3'd1;
  localparam logic [2:0] JC_GAP_ZERO  = 3'd2;
  localparam logic [2:0] JC_K_GE_N    = 3'd3;
  localparam logic [2:0] JC_NOT_AFTER = 3'd4;
  localparam logic [2:0] JC_KN_LT_N   = 3'd5;
  localparam logic [2:0] JC_J_NZ      = 3'd6;
  localparam logic [2:0] JC_NOT_LAST  = 3'd7;

  // store read address select
  localparam logic [1:0] RS_J  = 2'd0;
  localparam logic [1:0] RS_K  = 2'd1;
  localparam logic [1:0] RS_KN = 2'd2;
  localparam logic [1:0] RS_I  = 2'd3;

  typedef struct packed {
    logic [1:0]     wait_c;
    logic [2:0]     jmp_c;
    logic [PCW-1:0] tgt;
    logic [1:0]     rd_sel;
    logic           in_rdy;
    logic           gap_init;
    logic           gap_shift;
    logic           j_init;
    logic           j_dec;
    logic           k_from_j;
    logic           k_step;
    logic           held_ld;
    logic           wr_move;
    logic           wr_held;
    logic           out_ld;
    logic           i_inc;
    logic           i_clr;
    logic           cnt_clr;
  } ctl_t;

  typedef struct packed {
    logic in_last_acc;
    logic out_free;
    logic gap_zero;
    logic k_ge_n;
    logic not_after;
    logic kn_lt_n;
    logic j_nz;
    logic not_last;
  } stat_t;

endpackage
`default_nettype wire

@@ sv/sse_seq.sv @@
`default_nettype none
module sse_seq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire sse_pkg::stat_t stat,
  output sse_pkg::ctl_t       ctl,
  output logic                go,
  output logic [sse_pkg::PCW-1:0] pc
);
  import sse_pkg::*;

  logic [PCW-1:0] pc_r, pc_nxt;
  logic           jmp;

  // control store
  function automatic ctl_t ucode(input logic [PCW-1:0] a);
    ctl_t c;
    c = '0;
    unique case (a)
      ST_LOAD: begin
        c.wait_c = WT_IN_LAST;
        c.in_rdy = 1'b1;
      end
      ST_GINIT: begin
        c.gap_init = 1'b1;
        c.i_clr    = 1'b1;
      end
      ST_GTEST: begin
        c.jmp_c = JC_GAP_ZERO;
        c.tgt   = ST_EMIT_RD;
      end
      ST_JINIT: c.j_init = 1'b1;
      ST_RDJ: begin
        c.rd_sel   = RS_J;
        c.k_from_j = 1'b1;
      end
      ST_HOLD: begin
        c.held_ld = 1'b1;
        c.rd_sel  = RS_K;
        c.jmp_c   = JC_K_GE_N;
        c.tgt     = ST_PUT;
      end
      ST_CMP: begin
        c.rd_sel = RS_K;
        c.jmp_c  = JC_NOT_AFTER;
        c.tgt    = ST_PUT;
      end
      ST_MOVE: begin
        c.wr_move = 1'b1;
        c.k_step  = 1'b1;
        c.rd_sel  = RS_KN;
        c.jmp_c   = JC_KN_LT_N;
        c.tgt     = ST_CMP;
      end
      ST_PUT: begin
        c.wr_held = 1'b1;
        c.j_dec   = 1'b1;
        c.jmp_c   = JC_J_NZ;
        c.tgt     = ST_RDJ;
      end
      ST_GNEXT: begin
        c.gap_shift = 1'b1;
        c.jmp_c     = JC_ALWAYS;
        c.tgt       = ST_GTEST;
      end
      ST_EMIT_RD: c.rd_sel = RS_I;
      ST_EMIT_OUT: begin
        c.wait_c = WT_OUT_FREE;
        c.rd_sel = RS_I;
        c.out_ld = 1'b1;
        c.i_inc  = 1'b1;
        c.jmp_c  = JC_NOT_LAST;
        c.tgt    = ST_EMIT_RD;
      end
      ST_DONE: begin
        c.cnt_clr = 1'b1;
        c.jmp_c   = JC_ALWAYS;
        c.tgt     = ST_LOAD;
      end
      default: begin
        c.jmp_c = JC_ALWAYS;
        c.tgt   = ST_LOAD;
      end
    endcase
    return c;
  endfunction

  assign ctl = ucode(pc_r);
  assign pc  = pc_r;

  always_comb begin
    unique case (ctl.wait_c)
      WT_NONE:     go = 1'b1;
      WT_IN_LAST:  go = stat.in_last_acc;
      WT_OUT_FREE: go = stat.out_free;
      default:     go = 1'b1;
    endcase
  end

  always_comb begin
    unique case (ctl.jmp_c)
      JC_NONE:      jmp = 1'b0;
      JC_ALWAYS:    jmp = 1'b1;
      JC_GAP_ZERO:  jmp = stat.gap_zero;
      JC_K_GE_N:    jmp = stat.k_ge_n;
      JC_NOT_AFTER: jmp = stat.not_after;
      JC_KN_LT_N:   jmp = stat.kn_lt_n;
      JC_J_NZ:      jmp = stat.j_nz;
      JC_NOT_LAST:  jmp = stat.not_last;
      default:      jmp = 1'b0;
    endcase
  end

  always_comb begin
    priority if (!go) begin
      pc_nxt = pc_r;
    end else if (jmp) begin
      pc_nxt = ctl.tgt;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_LOAD;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/shell_sort_engine_core.sv @@
`default_nettype none
// shell sort engine: collects a set of signed 32-bit words, sorts them in place
// with halving gaps (n/2, n/4 ... 1, one gapped insertion pass per gap) and
// streams them back in order
// - input channel (in_valid/in_ready/in_data): one word per cycle while loading;
//   a word with is_last set closes the set; words past 64 are dropped and the
//   run is flagged as overflowed (a dropped last word still closes the set)
// - output channel (out_valid/out_ready/out_data): n words in sorted order,
//   is_last_res on the final one, overflowed constant over the run
// - config port (APB): bit 0 of the register at byte address 0 selects
//   descending order; write it only while the block is idle
// - sort: runs from a microcoded control store over a store with one write
//   and one registered read port; each insertion start reads, holds, compares
//   and puts back its word, each shifted word is moved and compared again;
//   each output word is read from the store, then loaded into the output
//   register, and a final step closes the run
// - in_ready is low from the last word of a set until the run is handed off;
//   a stalled receiver holds the output register and the sequencer waits
// - reset clears the count, overflow flag, output valid and sort order;
//   store contents are not cleared
module shell_sort_engine_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire sse_pkg::in_word_t             in_data,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output sse_pkg::out_word_t                 out_data,
  // config port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sse_pkg::CFG_AW-1:0]    paddr,
  input  wire logic [sse_pkg::CFG_DW-1:0]    pwdata,
  output logic      [sse_pkg::CFG_DW-1:0]    prdata,
  output logic                               pready
);
  import sse_pkg::*;

  ctl_t           ctl;
  stat_t          stat;
  logic           go;
  logic [PCW-1:0] pc;

  // set state
  logic [CW-1:0]  count_r, count_nxt;
  logic           ovf_r, ovf_nxt;
  logic           desc_r;

  // sort registers
  logic [AW-1:0]  gap_r;       // n/2 fits since n <= MAX_ITEMS
  logic [AW-1:0]  j_r;         // insertion start index
  logic [CW-1:0]  k_r;         // probe index, may run one gap past n
  logic [CW-1:0]  kn;          // next probe index
  logic [AW-1:0]  i_r;         // output index
  logic signed [31:0] held_r;

  // store
  logic signed [31:0] store_mem [MAX_ITEMS];
  logic signed [31:0] rd_q;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic signed [31:0] wr_data;
  logic               wr_en;

  // output register
  logic      out_valid_r;
  out_word_t out_word_r;

  logic in_acc, cfg_wr, goes_after;
  logic [AW-1:0] last_idx;

  sse_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl),
    .go    (go),
    .pc    (pc)
  );

  // ---------------- config port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[CFG_AW-1] == REG_DESCENDING) ? {{(CFG_DW-1){1'b0}}, desc_r}
                                                       : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r <= 1'b0;
    end else if (cfg_wr && paddr[CFG_AW-1] == REG_DESCENDING) begin
      desc_r <= pwdata[0];
    end
  end

  // ---------------- loading ----------------
  assign in_ready = ctl.in_rdy;
  assign in_acc   = in_valid && in_ready;
  assign last_idx = AW'(count_r - 1'b1);

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (in_acc) begin
      if (count_r < CW'(MAX_ITEMS)) begin
        count_nxt = count_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (ctl.cnt_clr) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // ---------------- status to sequencer ----------------
  assign kn         = k_r + {1'b0, gap_r};
  assign goes_after = desc_r ? (held_r < rd_q) : (held_r > rd_q);

  always_comb begin
    stat.in_last_acc = in_acc && in_data.is_last;
    stat.out_free    = !out_valid_r || out_ready;
    stat.gap_zero    = (gap_r == '0);
    stat.k_ge_n      = (k_r >= count_r);
    stat.not_after   = !goes_after;
    stat.kn_lt_n     = (kn < count_r);
    stat.j_nz        = (j_r != '0);
    stat.not_last    = (i_r != last_idx);
  end

  // ---------------- sort datapath ----------------
  always_ff @(posedge clk) begin
    if (go) begin
      if (ctl.gap_init)  gap_r <= count_r[CW-1:1];
      if (ctl.gap_shift) gap_r <= gap_r >> 1;
      if (ctl.j_init)    j_r   <= AW'(count_r - {1'b0, gap_r} - 1'b1);
      if (ctl.j_dec)     j_r   <= j_r - 1'b1;
      if (ctl.k_from_j)  k_r   <= {1'b0, j_r} + {1'b0, gap_r};
      if (ctl.k_step)    k_r   <= kn;
      if (ctl.held_ld)   held_r <= rd_q;
      if (ctl.i_clr)     i_r   <= '0;
      if (ctl.i_inc)     i_r   <= i_r + 1'b1;
    end
  end

  // store ports: one write, one registered read
  always_comb begin
    unique case (ctl.rd_sel)
      RS_J:    rd_addr = j_r;
      RS_K:    rd_addr = k_r[AW-1:0];
      RS_KN:   rd_addr = kn[AW-1:0];
      RS_I:    rd_addr = i_r;
      default: rd_addr = i_r;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(k_r - {1'b0, gap_r});
    wr_data = held_r;
    priority if (in_acc && count_r < CW'(MAX_ITEMS)) begin
      wr_en   = 1'b1;
      wr_addr = count_r[AW-1:0];
      wr_data = in_data.value;
    end else if (go && ctl.wr_move) begin
      wr_en   = 1'b1;
      wr_data = rd_q;
    end else if (go && ctl.wr_held) begin
      wr_en   = 1'b1;
    end else begin
      wr_en   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    rd_q <= store_mem[rd_addr];
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go && ctl.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && ctl.out_ld) begin
      out_word_r.sorted_value <= rd_q;
      out_word_r.is_last_res  <= !stat.not_last;
      out_word_r.overflowed   <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // ---------------- checks ----------------
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ITEMS))
    else $error("element count past capacity");

  a_last_starts_sort: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.is_last |=> pc == ST_GINIT)
    else $error("last word did not start the sort");

  a_move_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc == ST_MOVE |-> k_r < count_r && k_r >= {1'b0, gap_r})
    else $error("shift outside the loaded set");

  a_run_closes: assert property (@(posedge clk) disable iff (!rst_n)
    pc == ST_DONE |=> count_r == '0 && !ovf_r && pc == ST_LOAD)
    else $error("run did not close cleanly");

endmodule
`default_nettype wire

@@ test/tb_shell_sort_engine_core.sv @@
`timescale 1ns / 100ps

module tb_shell_sort_engine_core;
  import sse_pkg::*;

  // register map: index i sits at byte address 4*i, only index 0 is backed
  localparam logic [CFG_AW-1:0] ADDR_DESC  = CFG_AW'(REG_DESCENDING) << 2;
  localparam logic [CFG_AW-1:0] ADDR_SPARE = ADDR_DESC + CFG_AW'(4);

  localparam logic signed [31:0] V_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] V_MIN = 32'sh8000_0000;

  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam int SETTLE       = 12;      // wait for the run to close after the last word
  localparam int RANDOM_WORDS = 96;      // includes one set that overfills the store
  localparam int CYCLE_LIMIT  = 600000;

  // one line of the directed plan
  typedef enum logic [1:0] {ROW_WORD, ROW_TYPED, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [CFG_AW-1:0] addr;
    logic [31:0]       data;
    in_word_t          w;
    out_word_t         exp;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // predictor state: the set being loaded, its drop flag and the sort order
  logic signed [31:0] load_set[$];
  bit                 set_dropped = 1'b0;
  bit                 sort_desc = 1'b0;

  // sorted words still owed by the block, oldest first
  out_word_t sorted_due[$];

  plan_row_t plan[$];

  int  errors = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;        // no idling on either side while set
  bit  hold_armed = 1'b0;   // receiver holds off once when it sees the next word

  shell_sort_engine_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit: far beyond the slowest correct run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    if (errors < 50) $display("mismatch @%0d: %s", cycles, msg);
    errors++;
  endtask

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // extremes, a narrow band for duplicates, and full-range words
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return V_MAX;
      1: return V_MIN;
      2: return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
      3, 4, 5: return $signed(32'($urandom_range(0, 16))) - 32'sd8;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic logic moves_past(input logic signed [31:0] a, input logic signed [31:0] b);
    return sort_desc ? (a < b) : (a > b);
  endfunction

  // halving-gap shell sort of the loaded set, one gapped insertion pass per gap
  task automatic shell_sort_set();
    int n, gap, j, k;
    logic signed [31:0] held;
    n = load_set.size();
    for (gap = n / 2; gap > 0; gap = gap / 2) begin
      for (j = n - gap - 1; j >= 0; j--) begin
        held = load_set[j];
        k = j + gap;
        while (k < n && moves_past(held, load_set[k])) begin
          load_set[k - gap] = load_set[k];
          k += gap;
        end
        load_set[k - gap] = held;
      end
    end
  endtask

  // predictor step for one accepted word; a typed expectation replaces the
  // computed one on single-word sets
  task automatic load_and_sort(input in_word_t w, input bit typed, input out_word_t texp);
    out_word_t res;
    int i;
    // store full: word dropped, run flagged (also for a last word)
    if (load_set.size() < MAX_ITEMS) load_set.push_back(w.value);
    else set_dropped = 1'b1;
    if (w.is_last) begin
      shell_sort_set();
      if (typed) begin
        sorted_due.push_back(texp);
      end else begin
        for (i = 0; i < load_set.size(); i++) begin
          res.sorted_value = load_set[i];
          res.is_last_res  = (i == load_set.size() - 1);
          res.overflowed   = set_dropped;
          sorted_due.push_back(res);
        end
      end
      load_set.delete();
      set_dropped = 1'b0;
    end
  endtask

  // offer one word; valid stays up until the block takes it
  task automatic offer_word(input in_word_t w, input bit typed, input out_word_t texp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    load_and_sort(w, typed, texp);
  endtask

  // block idle: nothing owed, and the run close has had time to finish
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // apb write, then read the order bit back
  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // written at this edge; upper bits and the spare address are ignored
    if (addr == ADDR_DESC) sort_desc = data[0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_DESC;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[0] !== sort_desc)
      flag_mismatch($sformatf("order bit reads %b, want %b", prdata[0], sort_desc));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic plan_row_t row_word(input logic signed [31:0] v, input logic last);
    plan_row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.w    = {v, last};
    return r;
  endfunction

  function automatic plan_row_t row_typed(input logic signed [31:0] v, input out_word_t exp);
    plan_row_t r;
    r = '0;
    r.kind = ROW_TYPED;
    r.w    = {v, 1'b1};
    r.exp  = exp;
    return r;
  endfunction

  function automatic plan_row_t row_cfg(input logic [CFG_AW-1:0] addr, input logic [31:0] data);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.addr = addr;
    r.data = data;
    return r;
  endfunction

  // compare each sorted word with the oldest one owed
  task automatic check_sorted(input out_word_t got);
    out_word_t want;
    if (sorted_due.size() == 0) begin
      flag_mismatch($sformatf("unexpected word %0d", got.sorted_value));
    end else begin
      want = sorted_due.pop_front();
      if (got.sorted_value !== want.sorted_value)
        flag_mismatch($sformatf("sorted_value %0d, want %0d",
                                got.sorted_value, want.sorted_value));
      if (got.is_last_res !== want.is_last_res)
        flag_mismatch($sformatf("is_last_res %b, want %b", got.is_last_res, want.is_last_res));
      if (got.overflowed !== want.overflowed)
        flag_mismatch($sformatf("overflowed %b, want %b", got.overflowed, want.overflowed));
    end
  endtask

  // receiver: random stalls, plus one long hold-off so the block backs up
  // into its input while the sender keeps offering the next set
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) check_sorted(out_data);
      if (hold_armed && out_valid) begin
        hold_armed = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    int phase, sent, nsets, s, size, i;
    int r;
    in_word_t w;

    // directed plan, reset order first (ascending)
    // single-word sets at the extremes: the word comes straight back
    plan.push_back(row_typed(V_MAX, {V_MAX, 1'b1, 1'b0}));
    plan.push_back(row_typed(V_MIN, {V_MIN, 1'b1, 1'b0}));
    // extremes mixed with duplicates
    plan.push_back(row_word(32'sd5, 1'b0));
    plan.push_back(row_word(-32'sd3, 1'b0));
    plan.push_back(row_word(V_MAX, 1'b0));
    plan.push_back(row_word(V_MIN, 1'b0));
    plan.push_back(row_word(32'sd0, 1'b0));
    plan.push_back(row_word(-32'sd1, 1'b0));
    plan.push_back(row_word(32'sd5, 1'b1));
    // descending, with every upper bit of the write set
    plan.push_back(row_cfg(ADDR_DESC, 32'hFFFF_FFFF));
    plan.push_back(row_typed(32'sd0, {32'sd0, 1'b1, 1'b0}));
    plan.push_back(row_word(32'sd1, 1'b0));
    plan.push_back(row_word(V_MIN, 1'b0));
    plan.push_back(row_word(V_MAX, 1'b0));
    plan.push_back(row_word(-32'sd7, 1'b0));
    plan.push_back(row_word(32'sd2, 1'b1));
    plan.push_back(row_word(-32'sd1, 1'b0));
    plan.push_back(row_word(32'sd0, 1'b1));
    // spare address: order must stay descending
    plan.push_back(row_cfg(ADDR_SPARE, 32'h0000_0000));
    plan.push_back(row_word(32'sd3, 1'b0));
    plan.push_back(row_word(32'sd3, 1'b0));
    plan.push_back(row_word(-32'sd3, 1'b1));
    // back to ascending, bit 0 clear with the rest set
    plan.push_back(row_cfg(ADDR_DESC, 32'hFFFF_FFFE));
    plan.push_back(row_word(32'sd9, 1'b0));
    plan.push_back(row_word(-32'sd9, 1'b1));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[p]) begin
      case (plan[p].kind)
        ROW_CFG: begin
          settle_idle();
          cfg_write(plan[p].addr, plan[p].data);
        end
        ROW_TYPED: offer_word(plan[p].w, 1'b1, plan[p].exp);
        default:   offer_word(plan[p].w, 1'b0, plan[p].exp);
      endcase
    end

    // random phases: a config write between phases, sets back to back within
    hold_armed = 1'b1;
    phase = 0;
    sent  = 0;
    while (phase < 2 || sent < RANDOM_WORDS) begin
      if (phase > 0) begin
        settle_idle();
        cfg_write(($urandom_range(0, 4) == 0) ? ADDR_SPARE : ADDR_DESC, $urandom());
      end
      quiet = (phase > 0) && ($urandom_range(0, 3) == 0);
      nsets = $urandom_range(2, 6);
      for (s = 0; s < nsets && (s == 0 || sent < RANDOM_WORDS); s++) begin
        // one set that fills the store, then drops a plain word and the last word
        if (phase == 1 && s == 0) size = MAX_ITEMS + 2;
        else begin
          r = $urandom_range(0, 9);
          if (r < 7) size = $urandom_range(1, 6);
          else if (r < 9) size = $urandom_range(7, 16);
          else size = $urandom_range(17, 40);
        end
        for (i = 0; i < size; i++) begin
          w.value   = pick_value();
          w.is_last = (i == size - 1);
          offer_word(w, 1'b0, '0);
          sent++;
        end
      end
      phase++;
    end

    quiet = 1'b0;
    settle_idle();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
